>>> rtl/dsr_pkg.sv
// shared constants, types and helpers for the binary64 square root pipeline
`default_nettype none
package dsr_pkg;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned MANT_W    = 53;
    localparam int unsigned FRAC_W    = 52;
    localparam int unsigned EXP_W     = 11;
    // number of root bits resolved in each iteration stage
    localparam int unsigned BITS_PER_STAGE = 4;
    localparam int unsigned ITER_STAGES    = (MANT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    // remainder width: radicand is 107 bits, remainder fits in root width + 2
    localparam int unsigned REM_W = MANT_W + 2;
    localparam int unsigned RAD_W = 2 * MANT_W + 1;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = '1;
    localparam logic [11:0] EXP_OFFSET = 12'd486;

    // per item flow info carried alongside the iteration
    typedef struct packed {
        logic                  bypass;   // special case, result already known
        logic [DATA_W-1:0]     bypass_bits;
        logic [11:0]           biased_half;
    } dsr_side_t;

    // leading zero count of a 52-bit fraction (zeros above the top set bit)
    function automatic logic [5:0] lzc52(input logic [FRAC_W-1:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = FRAC_W - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
            end
            else if (!found) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

>>> rtl/dsr_unpack.sv
// front stage: special-case detection, subnormal normalization, radicand build
`default_nettype none
module dsr_unpack (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [dsr_pkg::DATA_W-1:0]    operand,
    output logic                               out_valid,
    output logic [dsr_pkg::RAD_W-1:0]          radicand,
    output dsr_pkg::dsr_side_t                 side
);
    import dsr_pkg::*;

    logic                 sign;
    logic [EXP_W-1:0]     expf;
    logic [FRAC_W-1:0]    frac;
    logic [5:0]           lz;
    logic [MANT_W-1:0]    mant;
    logic [11:0]          biased;
    logic [RAD_W-1:0]     rad_next;
    dsr_side_t            side_next;
    logic                 valid_reg;
    logic [RAD_W-1:0]     rad_reg;
    dsr_side_t            side_reg;

    always_comb
    begin
        sign = operand[DATA_W-1];
        expf = operand[DATA_W-2 -: EXP_W];
        frac = operand[FRAC_W-1:0];
        lz   = lzc52(frac);
        if (expf == '0) begin
            // subnormal: shift top set bit up to the hidden position
            mant   = {1'b0, frac} << (lz + 6'd1);
            biased = 12'd52 - {6'd0, lz} - 12'd1;
        end
        else begin
            mant   = {1'b1, frac};
            biased = {1'b0, expf} + 12'd51;
        end
        // radicand N = mant * 2^(52 + parity), as a 107-bit value (top bit spare)
        if (biased[0]) begin
            rad_next = {1'b0, mant, 53'd0};
        end
        else begin
            rad_next = {2'b0, mant, 52'd0};
        end
        side_next.biased_half = {1'b0, biased[11:1]} + EXP_OFFSET;
        side_next.bypass      = 1'b1;
        side_next.bypass_bits = '0;
        if (expf == EXP_ALL_ONES && frac != '0) begin
            side_next.bypass_bits = operand;
        end
        else if (sign) begin
            side_next.bypass_bits = '0;
        end
        else if (operand == '0) begin
            side_next.bypass_bits = '0;
        end
        else if (expf == EXP_ALL_ONES) begin
            side_next.bypass_bits = operand;
        end
        else begin
            side_next.bypass = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign radicand  = rad_reg;
    assign side      = side_reg;
endmodule
`default_nettype wire

>>> rtl/dsr_iter.sv
// one stage of the restoring root recurrence, a few root bits per stage
`default_nettype none
module dsr_iter #(
    parameter int unsigned FIRST_BIT = 52,
    parameter int unsigned NBITS     = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [dsr_pkg::RAD_W-1:0]     rad_in,
    input  wire logic [dsr_pkg::REM_W-1:0]     rem_in,
    input  wire logic [dsr_pkg::MANT_W-1:0]    root_in,
    input  wire dsr_pkg::dsr_side_t            side_in,
    output logic                               out_valid,
    output logic [dsr_pkg::RAD_W-1:0]          rad_out,
    output logic [dsr_pkg::REM_W-1:0]          rem_out,
    output logic [dsr_pkg::MANT_W-1:0]         root_out,
    output dsr_pkg::dsr_side_t                 side_out
);
    import dsr_pkg::*;

    logic [REM_W+1:0]   r;
    logic [REM_W+1:0]   t;
    logic [MANT_W-1:0]  q;
    logic [REM_W-1:0]   rem_next;
    logic [MANT_W-1:0]  root_next;
    logic               valid_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [MANT_W-1:0]  root_reg;
    dsr_side_t          side_reg;

    // remainder r = N_top - q^2; each step brings down two radicand bits
    always_comb
    begin
        r = {2'b0, rem_in};
        q = root_in;
        for (int k = 0; k < NBITS; k++) begin
            if (FIRST_BIT >= k) begin
                r = {r[REM_W-1:0], rad_in[2*(FIRST_BIT-k)+1 -: 2]};
                t = r - {q[MANT_W-2:0], 2'b01};
                q = {q[MANT_W-2:0], ~t[REM_W+1]};
                if (!t[REM_W+1]) begin
                    r = t;
                end
            end
        end
        rem_next  = r[REM_W-1:0];
        root_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;
endmodule
`default_nettype wire

>>> rtl/dsr_round.sv
// back stage: round to nearest, carry renormalization, result pack
`default_nettype none
module dsr_round (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [dsr_pkg::REM_W-1:0]     rem_in,
    input  wire logic [dsr_pkg::MANT_W-1:0]    root_in,
    input  wire dsr_pkg::dsr_side_t            side_in,
    output logic                               out_valid,
    output logic [dsr_pkg::DATA_W-1:0]         result
);
    import dsr_pkg::*;

    logic [MANT_W:0]    q;
    logic [11:0]        rexp;
    logic [DATA_W-1:0]  res_next;
    logic               valid_reg;
    logic [DATA_W-1:0]  res_reg;

    // N - s^2 > s  <=>  round up
    always_comb
    begin
        q    = {1'b0, root_in};
        rexp = side_in.biased_half;
        if (rem_in > {2'b0, root_in}) begin
            q = q + 1'b1;
        end
        if (q[MANT_W]) begin
            rexp = rexp + 12'd1;
        end
        res_next = {1'b0, rexp[EXP_W-1:0], q[FRAC_W-1:0]};
        if (side_in.bypass) begin
            res_next = side_in.bypass_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;
endmodule
`default_nettype wire

>>> rtl/double_square_root.sv
// top level of the pipelined binary64 square root
//
// usage: stream operands in on the s_axis group, roots come out on m_axis.
// s_axis_tdata carries one binary64 radicand, m_axis_tdata its rounded root.
// a transaction happens when tvalid and tready are both high at a clock edge.
// one operand may be taken every cycle; results keep input order.
// the pipe is 1 unpack stage, 14 iteration stages and 1 rounding stage.
// the depth is set by the root recurrence, up to four root bits per stage.
// whole pipeline advances together; when the receiver holds m_axis_tready low
// with a result waiting, every stage freezes and s_axis_tready drops, so no
// transaction is lost or repeated. a bubble at the output lets the pipe move.
// reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
// special inputs (nan, +inf, zero, negatives) take a bypass path that rides
// alongside the recurrence with the same latency.
`default_nettype none
module double_square_root (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [dsr_pkg::DATA_W-1:0]  s_axis_tdata,  // [63:0] operand_bits
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [dsr_pkg::DATA_W-1:0]       m_axis_tdata   // [63:0] root_bits
);
    import dsr_pkg::*;

    logic en;
    // pipe advances when output slot is empty or being drained
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    logic                 v   [0:ITER_STAGES];
    logic [RAD_W-1:0]     rad [0:ITER_STAGES];
    logic [REM_W-1:0]     rem [0:ITER_STAGES];
    logic [MANT_W-1:0]    rt  [0:ITER_STAGES];
    dsr_side_t            sd  [0:ITER_STAGES];

    dsr_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .operand   (s_axis_tdata),
        .out_valid (v[0]),
        .radicand  (rad[0]),
        .side      (sd[0])
    );
    assign rem[0] = '0;
    assign rt[0]  = '0;

    for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
        dsr_iter #(
            .FIRST_BIT (MANT_W - 1 - g * BITS_PER_STAGE),
            .NBITS     (BITS_PER_STAGE)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[g]),
            .rad_in    (rad[g]),
            .rem_in    (rem[g]),
            .root_in   (rt[g]),
            .side_in   (sd[g]),
            .out_valid (v[g+1]),
            .rad_out   (rad[g+1]),
            .rem_out   (rem[g+1]),
            .root_out  (rt[g+1]),
            .side_out  (sd[g+1])
        );
    end

    dsr_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v[ITER_STAGES]),
        .rem_in    (rem[ITER_STAGES]),
        .root_in   (rt[ITER_STAGES]),
        .side_in   (sd[ITER_STAGES]),
        .out_valid (m_axis_tvalid),
        .result    (m_axis_tdata)
    );

    // a stalled result must hold until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // ready follows the output slot
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    // only a passed-through nan can leave with the sign bit set
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[DATA_W-1] |->
            m_axis_tdata[DATA_W-2 -: EXP_W] == EXP_ALL_ONES &&
            m_axis_tdata[FRAC_W-1:0] != '0)
        else $error("negative root produced");
endmodule
`default_nettype wire
